// ===== hdl/cds_pkg.sv =====
`default_nettype none

package cds_pkg;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int OffW   = 5;
  localparam int WdayW  = 3;
  localparam int SumW   = 16;

  // item commands
  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_ADD  = 2'd1,
    CMD_SUB  = 2'd2
  } cmd_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [DayW-1:0]   new_day;
    logic [MonthW-1:0] new_month;
    logic [YearW-1:0]  new_year;
    logic [OffW-1:0]   offset;
  } item_t;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  // floor(x / 25) for any 14-bit x, by reciprocal multiply
  function automatic logic [9:0] div25(input logic [YearW-1:0] x);
    logic [27:0] p;
    p = 28'(x) * 28'd5243;
    return p[26:17];
  endfunction

  // gregorian leap rule: by 4 and not by 100, or by 400 (= by 16 and by 25)
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [YearW-1:0] r25;
    r25 = y - YearW'(div25(y)) * YearW'(25);
    return ((y[1:0] == 2'd0) && (r25 != '0)) || ((y[3:0] == 4'd0) && (r25 == '0));
  endfunction

  // month length, meaningless months count as 31 days
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // days in the year before the first of the month (non-leap)
  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  // x mod 7 for x below 2^15, by reciprocal multiply and subtracting 7 times the quotient
  function automatic logic [WdayW-1:0] mod7(input logic [SumW-1:0] x);
    logic [31:0]     p;
    logic [SumW-1:0] r;
    p = 32'(x) * 32'd37450;
    r = x - SumW'(p[31:18]) * SumW'(7);
    return r[WdayW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cds_date_step.sv =====
`default_nettype none

module cds_date_step (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          adv,
  input  wire logic          item_valid,
  input  wire cds_pkg::item_t item,
  output logic               date_valid_r,
  output cds_pkg::date_t     date_r
);
  import cds_pkg::*;

  date_t             date_nxt;
  logic              leap_cur;
  logic [DayW:0]     add_sum;
  logic [DayW-1:0]   len_cur;
  logic [MonthW-1:0] sub_month;
  logic [YearW-1:0]  sub_year;
  logic [DayW+1:0]   sub_t;

  assign leap_cur = is_leap(date_r.year);
  assign len_cur  = month_len(date_r.month, leap_cur);
  assign add_sum  = {1'b0, date_r.day} + {1'b0, item.offset};
  assign sub_t    = {2'b00, date_r.day} - {2'b00, item.offset};

  // month borrowed into on subtract; february only follows march, same year
  always_comb begin
    if (date_r.month == 4'd1) begin
      sub_month = 4'd12;
      sub_year  = date_r.year - YearW'(1);
    end else begin
      sub_month = date_r.month - MonthW'(1);
      sub_year  = date_r.year;
    end
  end

  // next date
  always_comb begin
    date_nxt = date_r;
    case (item.cmd)
      CMD_LOAD: begin
        date_nxt.day   = item.new_day;
        date_nxt.month = item.new_month;
        date_nxt.year  = item.new_year;
      end
      CMD_ADD: begin
        if (add_sum > {1'b0, len_cur}) begin
          date_nxt.day = DayW'(add_sum - {1'b0, len_cur});
          if (date_r.month == 4'd12) begin
            date_nxt.month = 4'd1;
            date_nxt.year  = date_r.year + YearW'(1);
          end else begin
            date_nxt.month = date_r.month + MonthW'(1);
          end
        end else begin
          date_nxt.day = add_sum[DayW-1:0];
        end
      end
      CMD_SUB: begin
        if ($signed(sub_t) < 7'sd1) begin
          date_nxt.month = sub_month;
          date_nxt.year  = sub_year;
          date_nxt.day   = DayW'(sub_t + {2'b00, month_len(sub_month, leap_cur)});
        end else begin
          date_nxt.day = sub_t[DayW-1:0];
        end
      end
      default: date_nxt = date_r;
    endcase
  end

  // held date and stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      date_valid_r <= 1'b0;
      date_r.day   <= DayW'(1);
      date_r.month <= MonthW'(1);
      date_r.year  <= YearW'(1);
    end else if (adv) begin
      date_valid_r <= item_valid;
      if (item_valid) begin
        date_r <= date_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cds_weekday.sv =====
`default_nettype none

module cds_weekday (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           adv,
  input  wire logic           date_valid,
  input  wire cds_pkg::date_t date,
  output logic                res_valid_r,
  output cds_pkg::date_t      res_date_r,
  output logic                res_leap_r,
  output logic [cds_pkg::WdayW-1:0] res_wday_r
);
  import cds_pkg::*;

  logic            leap;
  logic [YearW:0]  py;
  logic [9:0]      q100;
  logic [9:0]      q400;
  logic            adj;
  logic [SumW-1:0] sum_nxt;

  logic            s_valid_r;
  date_t           s_date_r;
  logic            s_leap_r;
  logic [SumW-1:0] s_sum_r;

  // day count mod 7: 365 = 1 mod 7, centuries via divide by 25
  assign leap = is_leap(date.year);
  assign py   = {1'b0, date.year} + 15'd399;
  assign q100 = div25(YearW'(py[YearW:2]));
  assign q400 = div25(YearW'(py[YearW:4]));

  always_comb begin
    adj = 1'b0;
    if (date.month inside {[4'd3:4'd12]}) begin
      adj = leap;
    end
  end

  assign sum_nxt = SumW'(days_before(date.month)) + SumW'(date.day) + SumW'(7'd6)
                 + SumW'(adj) + SumW'(py) + SumW'(py[YearW:2]) + SumW'(q400)
                 + SumW'(8'd168) - SumW'(q100);

  // partial sum stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (adv) begin
      s_valid_r <= date_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_date_r <= date;
      s_leap_r <= leap;
      s_sum_r  <= sum_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (adv) begin
      res_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_date_r <= s_date_r;
      res_leap_r <= s_leap_r;
      res_wday_r <= mod7(s_sum_r);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/calendar_date_stepper.sv =====
// path: from input transfer to result valid the item passes the input register,
//   date register, day-count register and result register
// throughput: one item per cycle while adv is high; the next held date is computed combinationally
// stall: all stages advance together whenever the result register is empty or taken
// reset: synchronous active-low rst_n empties the pipeline and sets the date to 1/1/1
`default_nettype none

module calendar_date_stepper (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // new_day[4:0], new_month[8:5], new_year[22:9], offset[27:23]
  input  wire logic [31:0] in_tdata,
  // command[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // cur_day[4:0], cur_month[8:5], cur_year[22:9], leap_flag[23], weekday[26:24]
  output logic [31:0]      out_tdata
);
  import cds_pkg::*;

  logic  adv;
  logic  in_valid_r;
  item_t item_r;
  logic  date_valid;
  date_t date;
  logic  res_valid;
  date_t res_date;
  logic  res_leap;
  logic [WdayW-1:0] res_wday;

  // whole pipeline moves when the result register can take a new value
  assign adv       = !res_valid || out_tready;
  assign in_tready = adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (adv) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      item_r.cmd       <= in_tuser;
      item_r.new_day   <= in_tdata[4:0];
      item_r.new_month <= in_tdata[8:5];
      item_r.new_year  <= in_tdata[22:9];
      item_r.offset    <= in_tdata[27:23];
    end
  end

  cds_date_step u_date_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .item_valid   (in_valid_r),
    .item         (item_r),
    .date_valid_r (date_valid),
    .date_r       (date)
  );

  cds_weekday u_weekday (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .date_valid  (date_valid),
    .date        (date),
    .res_valid_r (res_valid),
    .res_date_r  (res_date),
    .res_leap_r  (res_leap),
    .res_wday_r  (res_wday)
  );

  // result transfer
  assign out_tvalid = res_valid;
  assign out_tdata  = {5'd0, res_wday, res_leap, res_date.year, res_date.month, res_date.day};

endmodule

`default_nettype wire
